/* hw/rtl/stroke_append_bounds_validator_top_assert.svh */
// Assertion macros for the stroke append bounds validator.
// Each property is sampled on clk_i and disabled while rst_ni is low.
`ifndef STROKE_APPEND_BOUNDS_VALIDATOR_TOP_ASSERT_SVH
`define STROKE_APPEND_BOUNDS_VALIDATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define SABV_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SABV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sabv_pkg.sv */
package sabv_pkg;

  localparam int WORLD_WIDTH  = 1024;
  localparam int WORLD_HEIGHT = 768;

  localparam int ACC_W = 18;
  localparam int RQ_W  = 11;

  // Quarter-pixel limits of the world.
  localparam logic [ACC_W-1:0] X_LIMIT = ACC_W'(4 * WORLD_WIDTH);
  localparam logic [ACC_W-1:0] Y_LIMIT = ACC_W'(4 * WORLD_HEIGHT);

  // Radius rounding from 1/256 px up to 1/4 px.
  localparam logic [16:0] RADIUS_ROUND = 17'd63;
  localparam int          RADIUS_SHIFT = 6;   // divide by 64

  localparam logic [ACC_W:0] CEIL_ADD = (ACC_W+1)'(3);

  localparam logic [16:0] LEN_SAT = 17'h10000;
  localparam logic [31:0] REV_MAX = 32'hFFFF_FFFF;

  localparam logic [16:0] WIDTH_PX  = 17'(WORLD_WIDTH);
  localparam logic [16:0] HEIGHT_PX = 17'(WORLD_HEIGHT);

  // Op codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Tool codes
  localparam logic [1:0] TOOL_PEN    = 2'd0;
  localparam logic [1:0] TOOL_ERASER = 2'd1;

  // Config register indexes
  localparam logic CFG_RECORD_CAP = 1'b0;
  localparam logic CFG_SAMPLE_CAP = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] x_qpel;
    logic [15:0] y_qpel;
    logic [15:0] radius_fine;
    logic [31:0] stamp_ms;
    logic [1:0]  stroke_tool;
    logic [31:0] stroke_color;
    logic        last_sample;
  } sabv_in_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] record_index;
    logic [31:0] revision;
    logic [23:0] sample_start;
    logic [15:0] samples_in_stroke;
    logic [13:0] bound_left;
    logic [13:0] bound_top;
    logic [13:0] bound_right;
    logic [13:0] bound_bottom;
    logic        record_tool;
    logic [31:0] record_color;
  } sabv_out_t;

  // Extent and static validity of one sample.
  typedef struct packed {
    logic [ACC_W-1:0] lo_x;
    logic [ACC_W-1:0] lo_y;
    logic [ACC_W-1:0] hi_x;
    logic [ACC_W-1:0] hi_y;
    logic             bad;
  } sample_ext_t;

endpackage

/* hw/rtl/stroke_append_bounds_validator_top.sv */
// Channel   Direction  Signals                                  Transfer when
// in        input      in_valid_i, in_stall_o, in_data_i        valid high, stall low
// out       output     out_valid_o, out_stall_i, out_data_o     valid high, stall low
// cfg       input      cfg_valid_i, cfg_ready_o, cfg_index_i,   valid and ready high
//                      cfg_data_i
//
// One input item per cycle while in_stall_o is low. A final sample passes
// through the input register and then the result register to give its record.
// The counters and stroke accumulators update as the item leaves the input register.
// Reset clears counters, capacities and both valid flags and restarts the accumulators.
// A stalled result holds the input register; out_stall_i reaches in_stall_o
// only while both registers are full.
`include "stroke_append_bounds_validator_top_assert.svh"

module stroke_append_bounds_validator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sabv_pkg::sabv_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sabv_pkg::sabv_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [23:0]         cfg_data_i
);

  // Input register
  logic               s1_valid_q;
  sabv_pkg::sabv_in_t s1_data_q;
  logic               s1_fire, advance, in_fire;

  // Config
  logic [15:0] rec_cap_q;
  logic [23:0] smp_cap_q;

  // Counters and stroke accumulators
  logic [15:0]               ops_q, ops_d;
  logic [23:0]               samp_q, samp_d;
  logic [31:0]               rev_q, rev_d;
  logic [16:0]               len_q, len_d;
  logic [sabv_pkg::ACC_W-1:0] min_x_q, min_x_d, min_y_q, min_y_d;
  logic [sabv_pkg::ACC_W-1:0] max_x_q, max_x_d, max_y_q, max_y_d;
  logic [31:0]               prev_t_q, prev_t_d;
  logic                      inv_q, inv_d;

  // Result register
  logic                out_valid_q, out_valid_d;
  sabv_pkg::sabv_out_t out_data_q, out_data_d;

  sabv_pkg::sample_ext_t ext;

  logic [16:0]                len_new;
  logic                       inv_new, time_bad;
  logic [sabv_pkg::ACC_W-1:0] min_x_new, min_y_new, max_x_new, max_y_new;
  logic [23:0]                free_space;
  logic [sabv_pkg::ACC_W:0]   x_ceil_sum, y_ceil_sum;
  logic [16:0]                x1, y1;
  logic                       is_clear, is_last, ok;

  sabv_sample u_sample (
    .sample_i (s1_data_q),
    .ext_o    (ext)
  );

  assign advance    = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Per-sample combine with the running stroke state
  always_comb begin
    is_clear  = (s1_data_q.op == sabv_pkg::OP_CLEAR);
    is_last   = !is_clear && s1_data_q.last_sample;
    len_new   = (len_q == sabv_pkg::LEN_SAT) ? len_q : len_q + 17'd1;
    time_bad  = (len_q != '0) && (s1_data_q.stamp_ms < prev_t_q);
    inv_new   = inv_q || ext.bad || time_bad;
    min_x_new = (ext.lo_x < min_x_q) ? ext.lo_x : min_x_q;
    min_y_new = (ext.lo_y < min_y_q) ? ext.lo_y : min_y_q;
    max_x_new = (ext.hi_x > max_x_q) ? ext.hi_x : max_x_q;
    max_y_new = (ext.hi_y > max_y_q) ? ext.hi_y : max_y_q;

    // free space counts as zero once the capacity was lowered below the fill
    free_space = (samp_q <= smp_cap_q) ? smp_cap_q - samp_q : '0;

    ok = (rec_cap_q != '0) && (smp_cap_q != '0) &&
         !len_new[16] &&
         (ops_q < rec_cap_q) &&
         (rev_q != sabv_pkg::REV_MAX) &&
         (24'(len_new) <= free_space) &&
         (s1_data_q.stroke_tool == sabv_pkg::TOOL_PEN ||
          s1_data_q.stroke_tool == sabv_pkg::TOOL_ERASER) &&
         !inv_new;

    x_ceil_sum = {1'b0, max_x_new} + sabv_pkg::CEIL_ADD;
    y_ceil_sum = {1'b0, max_y_new} + sabv_pkg::CEIL_ADD;
    x1 = (x_ceil_sum[sabv_pkg::ACC_W:2] > sabv_pkg::WIDTH_PX) ?
         sabv_pkg::WIDTH_PX : x_ceil_sum[sabv_pkg::ACC_W:2];
    y1 = (y_ceil_sum[sabv_pkg::ACC_W:2] > sabv_pkg::HEIGHT_PX) ?
         sabv_pkg::HEIGHT_PX : y_ceil_sum[sabv_pkg::ACC_W:2];
  end

  // Next state of counters and accumulators
  always_comb begin
    ops_d    = ops_q;
    samp_d   = samp_q;
    rev_d    = rev_q;
    len_d    = len_q;
    min_x_d  = min_x_q;
    min_y_d  = min_y_q;
    max_x_d  = max_x_q;
    max_y_d  = max_y_q;
    prev_t_d = prev_t_q;
    inv_d    = inv_q;
    if (s1_fire) begin
      if (is_clear || is_last) begin
        len_d    = '0;
        min_x_d  = sabv_pkg::X_LIMIT;
        min_y_d  = sabv_pkg::Y_LIMIT;
        max_x_d  = '0;
        max_y_d  = '0;
        prev_t_d = '0;
        inv_d    = 1'b0;
      end else begin
        len_d    = len_new;
        min_x_d  = min_x_new;
        min_y_d  = min_y_new;
        max_x_d  = max_x_new;
        max_y_d  = max_y_new;
        prev_t_d = s1_data_q.stamp_ms;
        inv_d    = inv_new;
      end
      if (is_clear) begin
        ops_d  = '0;
        samp_d = '0;
        rev_d  = '0;
      end else if (is_last && ok) begin
        ops_d  = ops_q + 16'd1;
        samp_d = samp_q + 24'(len_new);
        rev_d  = rev_q + 32'd1;
      end
    end
  end

  // Result register load
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (s1_fire && is_last) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      if (ok) begin
        out_data_d.accepted          = 1'b1;
        out_data_d.record_index      = ops_q;
        out_data_d.revision          = rev_q + 32'd1;
        out_data_d.sample_start      = samp_q;
        out_data_d.samples_in_stroke = len_new[15:0];
        out_data_d.bound_left        = min_x_new[15:2];
        out_data_d.bound_top         = min_y_new[15:2];
        out_data_d.bound_right       = x1[13:0];
        out_data_d.bound_bottom      = y1[13:0];
        out_data_d.record_tool       = s1_data_q.stroke_tool[0];
        out_data_d.record_color      = s1_data_q.stroke_color;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rec_cap_q   <= '0;
      smp_cap_q   <= '0;
      ops_q       <= '0;
      samp_q      <= '0;
      rev_q       <= '0;
      len_q       <= '0;
      min_x_q     <= sabv_pkg::X_LIMIT;
      min_y_q     <= sabv_pkg::Y_LIMIT;
      max_x_q     <= '0;
      max_y_q     <= '0;
      prev_t_q    <= '0;
      inv_q       <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          sabv_pkg::CFG_RECORD_CAP: rec_cap_q <= cfg_data_i[15:0];
          sabv_pkg::CFG_SAMPLE_CAP: smp_cap_q <= cfg_data_i;
          default: ;
        endcase
      end
      ops_q    <= ops_d;
      samp_q   <= samp_d;
      rev_q    <= rev_d;
      len_q    <= len_d;
      min_x_q  <= min_x_d;
      min_y_q  <= min_y_d;
      max_x_q  <= max_x_d;
      max_y_q  <= max_y_d;
      prev_t_q <= prev_t_d;
      inv_q    <= inv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
    out_data_q <= out_data_d;
  end

  `SABV_ASSERT_IMPL(a_reject_zero, out_valid_o && !out_data_o.accepted, out_data_o == '0, "rejected record carries nonzero fields")
  `SABV_ASSERT_IMPL(a_bounds_order, out_valid_o && out_data_o.accepted, (out_data_o.bound_left <= out_data_o.bound_right) && (out_data_o.bound_top <= out_data_o.bound_bottom), "accepted record has inverted bounds")
  `SABV_ASSERT_NEXT(a_clear_zeroes, s1_fire && is_clear, (ops_q == '0) && (samp_q == '0) && (rev_q == '0), "clear did not zero counters")
  `SABV_ASSERT_NEXT(a_rev_step, s1_fire && is_last && ok, rev_q == $past(rev_q) + 32'd1, "accepted stroke did not advance revision")
  `SABV_ASSERT_IMPL(a_stall_full, in_stall_o, s1_valid_q && out_valid_q, "input stalled with a free stage")

endmodule

/* hw/rtl/sabv_sample.sv */
module sabv_sample (
  input  sabv_pkg::sabv_in_t    sample_i,
  output sabv_pkg::sample_ext_t ext_o
);

  logic [16:0]                  rad_sum;
  logic [sabv_pkg::RQ_W-1:0]    rq;
  logic [15:0]                  rq16;

  assign rad_sum = {1'b0, sample_i.radius_fine} + sabv_pkg::RADIUS_ROUND;
  assign rq      = rad_sum[sabv_pkg::RADIUS_SHIFT +: sabv_pkg::RQ_W];
  assign rq16    = 16'(rq);

  always_comb begin
    ext_o.lo_x = (sample_i.x_qpel > rq16) ?
                 sabv_pkg::ACC_W'(sample_i.x_qpel - rq16) : '0;
    ext_o.lo_y = (sample_i.y_qpel > rq16) ?
                 sabv_pkg::ACC_W'(sample_i.y_qpel - rq16) : '0;
    ext_o.hi_x = sabv_pkg::ACC_W'(sample_i.x_qpel) + sabv_pkg::ACC_W'(rq);
    ext_o.hi_y = sabv_pkg::ACC_W'(sample_i.y_qpel) + sabv_pkg::ACC_W'(rq);
    ext_o.bad  = (sabv_pkg::ACC_W'(sample_i.x_qpel) > sabv_pkg::X_LIMIT) ||
                 (sabv_pkg::ACC_W'(sample_i.y_qpel) > sabv_pkg::Y_LIMIT) ||
                 (sample_i.radius_fine == '0);
  end

endmodule

/* dv/stroke_record_checker.sv */
`timescale 1ns / 1ps

module stroke_record_checker
  import sabv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  sabv_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  sabv_out_t out_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  logic      cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output int        pending_o,
  output int        errors_o
);

  localparam int unsigned X_QMAX = 4 * WORLD_WIDTH;
  localparam int unsigned Y_QMAX = 4 * WORLD_HEIGHT;

  // Capacity registers as last written
  logic [15:0] rec_cap;
  logic [23:0] smp_cap;

  // Log counters
  logic [15:0] ops_stored;
  logic [23:0] samples_stored;
  logic [31:0] doc_revision;

  // Running stroke
  logic [16:0] run_length;
  logic [17:0] lo_x_acc, lo_y_acc, hi_x_acc, hi_y_acc;
  logic [31:0] last_time;
  logic        run_bad;

  sabv_out_t expected_records[$];
  int        mismatches;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic restart_stroke();
    run_length = '0;
    lo_x_acc   = 18'(X_QMAX);
    lo_y_acc   = 18'(Y_QMAX);
    hi_x_acc   = '0;
    hi_y_acc   = '0;
    last_time  = '0;
    run_bad    = 1'b0;
  endtask

  // Folds one accepted item into the log state; a final sample queues its record.
  task automatic predict_sample(input sabv_in_t s);
    logic [16:0] rq;
    logic [17:0] lo, hi;
    logic [23:0] free_space;
    logic [18:0] right, bottom;
    logic        ok;
    sabv_out_t   rec;
    if (s.op == OP_CLEAR) begin
      ops_stored     = '0;
      samples_stored = '0;
      doc_revision   = '0;
      restart_stroke();
      return;
    end
    if (s.x_qpel > X_QMAX || s.y_qpel > Y_QMAX || s.radius_fine == '0) run_bad = 1'b1;
    if (run_length != '0 && s.stamp_ms < last_time) run_bad = 1'b1;
    last_time = s.stamp_ms;

    // radius rounded up to quarter pixels
    rq = ({1'b0, s.radius_fine} + 17'd63) >> 6;
    lo = (s.x_qpel > rq) ? 18'(s.x_qpel - rq) : '0;
    if (lo < lo_x_acc) lo_x_acc = lo;
    lo = (s.y_qpel > rq) ? 18'(s.y_qpel - rq) : '0;
    if (lo < lo_y_acc) lo_y_acc = lo;
    hi = 18'(s.x_qpel) + 18'(rq);
    if (hi > hi_x_acc) hi_x_acc = hi;
    hi = 18'(s.y_qpel) + 18'(rq);
    if (hi > hi_y_acc) hi_y_acc = hi;
    if (run_length < LEN_SAT) run_length++;

    if (!s.last_sample) return;

    rec = '0;
    free_space = (samples_stored <= smp_cap) ? smp_cap - samples_stored : '0;
    ok = rec_cap != '0 && smp_cap != '0 && run_length <= 17'hFFFF &&
         ops_stored < rec_cap && doc_revision != REV_MAX &&
         24'(run_length) <= free_space && s.stroke_tool <= TOOL_ERASER && !run_bad;
    if (ok) begin
      right  = ({1'b0, hi_x_acc} + 19'd3) >> 2;
      bottom = ({1'b0, hi_y_acc} + 19'd3) >> 2;
      if (right > WORLD_WIDTH) right = 19'(WORLD_WIDTH);
      if (bottom > WORLD_HEIGHT) bottom = 19'(WORLD_HEIGHT);
      rec.accepted          = 1'b1;
      rec.record_index      = ops_stored;
      rec.revision          = doc_revision + 32'd1;
      rec.sample_start      = samples_stored;
      rec.samples_in_stroke = run_length[15:0];
      rec.bound_left        = 14'(lo_x_acc >> 2);
      rec.bound_top         = 14'(lo_y_acc >> 2);
      rec.bound_right       = right[13:0];
      rec.bound_bottom      = bottom[13:0];
      rec.record_tool       = s.stroke_tool[0];
      rec.record_color      = s.stroke_color;
      ops_stored     = ops_stored + 16'd1;
      samples_stored = samples_stored + 24'(run_length);
      doc_revision   = doc_revision + 32'd1;
    end
    expected_records.push_back(rec);
    restart_stroke();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sabv_out_t e, g;
    if (!rst_ni) begin
      rec_cap        = '0;
      smp_cap        = '0;
      ops_stored     = '0;
      samples_stored = '0;
      doc_revision   = '0;
      restart_stroke();
      expected_records.delete();
      mismatches = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_RECORD_CAP) rec_cap = cfg_data_i[15:0];
        else smp_cap = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        g = out_data_i;
        if (expected_records.size() == 0) begin
          report_mismatch($sformatf("record with none expected: %h", g));
        end else begin
          e = expected_records.pop_front();
          if (g.accepted !== e.accepted)
            report_mismatch($sformatf("accepted %h exp %h", g.accepted, e.accepted));
          if (g.record_index !== e.record_index)
            report_mismatch($sformatf("record_index %h exp %h",
                                      g.record_index, e.record_index));
          if (g.revision !== e.revision)
            report_mismatch($sformatf("revision %h exp %h", g.revision, e.revision));
          if (g.sample_start !== e.sample_start)
            report_mismatch($sformatf("sample_start %h exp %h",
                                      g.sample_start, e.sample_start));
          if (g.samples_in_stroke !== e.samples_in_stroke)
            report_mismatch($sformatf("samples_in_stroke %h exp %h",
                                      g.samples_in_stroke, e.samples_in_stroke));
          if (g.bound_left !== e.bound_left)
            report_mismatch($sformatf("bound_left %h exp %h", g.bound_left, e.bound_left));
          if (g.bound_top !== e.bound_top)
            report_mismatch($sformatf("bound_top %h exp %h", g.bound_top, e.bound_top));
          if (g.bound_right !== e.bound_right)
            report_mismatch($sformatf("bound_right %h exp %h", g.bound_right, e.bound_right));
          if (g.bound_bottom !== e.bound_bottom)
            report_mismatch($sformatf("bound_bottom %h exp %h",
                                      g.bound_bottom, e.bound_bottom));
          if (g.record_tool !== e.record_tool)
            report_mismatch($sformatf("record_tool %h exp %h", g.record_tool, e.record_tool));
          if (g.record_color !== e.record_color)
            report_mismatch($sformatf("record_color %h exp %h",
                                      g.record_color, e.record_color));
        end
      end
      if (in_valid_i && !in_stall_i) predict_sample(in_data_i);
      pending_o <= expected_records.size();
      errors_o  <= mismatches;
    end
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import sabv_pkg::*;

  localparam int unsigned X_QMAX = 4 * WORLD_WIDTH;
  localparam int unsigned Y_QMAX = 4 * WORLD_HEIGHT;
  localparam logic [1:0] TOOL_RSVD2 = 2'd2;
  localparam logic [1:0] TOOL_RSVD3 = 2'd3;
  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 300;
  localparam int PHASE_ITEMS = 250;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  sabv_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  sabv_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [23:0] cfg_data;
  int          pending;
  int          errors;

  int items_sent = 0;
  int rand_base  = 0;
  int quiet_left = 0;

  stroke_append_bounds_validator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  stroke_record_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic sabv_in_t stroke_pt(input logic [15:0] x, input logic [15:0] y,
                                         input logic [15:0] rad, input logic [31:0] t,
                                         input logic [1:0] tool, input logic [31:0] color,
                                         input logic last);
    sabv_in_t s;
    s.op           = OP_SAMPLE;
    s.x_qpel       = x;
    s.y_qpel       = y;
    s.radius_fine  = rad;
    s.stamp_ms     = t;
    s.stroke_tool  = tool;
    s.stroke_color = color;
    s.last_sample  = last;
    return s;
  endfunction

  // Fully random item; decoded as a sample unless op is forced afterwards.
  function automatic sabv_in_t noise_item();
    sabv_in_t s;
    s = stroke_pt(16'($urandom), 16'($urandom), 16'($urandom), $urandom, 2'($urandom),
                  $urandom, 1'($urandom));
    return s;
  endfunction

  function automatic sabv_in_t clear_item();
    sabv_in_t s;
    s = noise_item();
    s.op = OP_CLEAR;
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Gap goes before the transfer so valid is never dropped and raised in one step.
  task automatic send_item(input sabv_in_t d);
    int gap;
    gap = 0;
    if (quiet_left > 0) quiet_left--;
    else if ($urandom_range(0, 59) == 0) quiet_left = $urandom_range(20, 60);
    else gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // samples that give no record may still be in flight
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input logic [15:0] rc, input logic [23:0] sc);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_RECORD_CAP;
    cfg_data  <= 24'(rc);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= CFG_SAMPLE_CAP;
    cfg_data  <= sc;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_pos(input int unsigned limit);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 16'(limit);
    return 16'($urandom_range(0, limit));
  endfunction

  task automatic send_stroke(input int len, input bit valid_only);
    int          bad_at;
    logic [31:0] t, stride;
    logic [1:0]  tool;
    sabv_in_t    s;
    bad_at = (!valid_only && $urandom_range(0, 11) == 0) ? $urandom_range(0, len - 1) : -1;
    t = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                    : 32'($urandom_range(0, 100000));
    tool = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
    if (valid_only) tool = TOOL_PEN;
    for (int i = 0; i < len; i++) begin
      stride = valid_only ? 32'd1 : 32'($urandom_range(0, 20));
      if (32'hFFFF_FFFF - t >= stride) t = t + stride;
      s = stroke_pt(pick_pos(X_QMAX), pick_pos(Y_QMAX),
                    $urandom_range(0, 1) ? 16'($urandom_range(1, 255))
                                         : 16'($urandom_range(1, 65535)),
                    t, 2'($urandom), $urandom, i == len - 1);
      if (i == len - 1) s.stroke_tool = tool;
      if (i == bad_at) begin
        case ($urandom_range(0, 3))
          0: s.x_qpel = 16'($urandom_range(X_QMAX + 1, 65535));
          1: s.y_qpel = 16'($urandom_range(Y_QMAX + 1, 65535));
          2: s.radius_fine = '0;
          default: begin
            if (i > 0 && t != '0) begin
              // time goes backwards
              t = 32'($urandom_range(0, t - 1));
              s.stamp_ms = t;
            end else begin
              s.radius_fine = '0;
            end
          end
        endcase
      end
      send_item(s);
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 16);
    return $urandom_range(17, 60);
  endfunction

  // Receiver: short stalls, stall-free stretches, and one long hold-off.
  initial begin
    bit held;
    int r;
    held = 1'b0;
    out_stall <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && rand_base > 0 && items_sent - rand_base >= 300) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        held = 1'b1;
      end
      out_stall <= 1'b0;
      r = $urandom_range(0, 99);
      repeat ((r < 10) ? $urandom_range(40, 120) : $urandom_range(1, 6)) @(posedge clk_i);
      out_stall <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 60) @(posedge clk_i);
      else if (r < 90) repeat ($urandom_range(2, 4)) @(posedge clk_i);
      else repeat ($urandom_range(10, 30)) @(posedge clk_i);
    end
  end

  // Ends the run if nothing moves on any channel for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [15:0] rc_tab [5];
    logic [23:0] sc_tab [5];
    int          start;
    int          r;
    rc_tab = '{16'hFFFF, 16'd4, 16'd1, 16'd300, 16'hFFFF};
    sc_tab = '{24'hFF_FFFF, 24'd60, 24'd1, 24'd2000, 24'hFF_FFFF};
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_RECORD_CAP;
    cfg_data  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // both capacities zero out of reset, then only the sample store
    send_item(stroke_pt(16'd100, 16'd100, 16'd64, 32'd0, TOOL_PEN, $urandom, 1'b1));
    drain();
    configure(16'hFFFF, 24'd0);
    send_item(stroke_pt(16'd100, 16'd100, 16'd64, 32'd0, TOOL_PEN, $urandom, 1'b1));
    drain();
    configure(16'hFFFF, 24'hFF_FFFF);

    // field extremes, invalid positions and radius
    send_item(stroke_pt(16'd0, 16'd0, 16'd1, 32'd5, TOOL_PEN, 32'd0, 1'b1));
    send_item(stroke_pt(16'(X_QMAX), 16'(Y_QMAX), 16'hFFFF, 32'hFFFF_FFFF, TOOL_ERASER,
                        32'hFFFF_FFFF, 1'b1));
    send_item(stroke_pt(16'(X_QMAX + 1), 16'd0, 16'd64, 32'd0, TOOL_PEN, $urandom, 1'b1));
    send_item(stroke_pt(16'd0, 16'(Y_QMAX + 1), 16'd64, 32'd0, TOOL_PEN, $urandom, 1'b1));
    send_item(stroke_pt(16'hFFFF, 16'hFFFF, 16'd64, 32'd0, TOOL_PEN, $urandom, 1'b1));
    send_item(stroke_pt(16'd200, 16'd200, 16'd0, 32'd0, TOOL_PEN, $urandom, 1'b1));
    // decreasing time rejects, equal time passes
    send_item(stroke_pt(16'd10, 16'd10, 16'd65, 32'd100, TOOL_PEN, $urandom, 1'b0));
    send_item(stroke_pt(16'd20, 16'd30, 16'd65, 32'd99, TOOL_PEN, $urandom, 1'b1));
    send_item(stroke_pt(16'd10, 16'd10, 16'd63, 32'd7, TOOL_PEN, $urandom, 1'b0));
    send_item(stroke_pt(16'd2000, 16'd1500, 16'd300, 32'd7, TOOL_ERASER, $urandom, 1'b1));
    // reserved tools
    send_item(stroke_pt(16'd50, 16'd50, 16'd64, 32'd1, TOOL_RSVD2, $urandom, 1'b1));
    send_item(stroke_pt(16'd50, 16'd50, 16'd64, 32'd1, TOOL_RSVD3, $urandom, 1'b1));
    // time restarts with each stroke
    send_item(stroke_pt(16'd60, 16'd70, 16'd128, 32'd1000, TOOL_PEN, $urandom, 1'b1));
    send_item(stroke_pt(16'd80, 16'd90, 16'd128, 32'd5, TOOL_PEN, $urandom, 1'b1));
    // clear in the middle of a stroke drops it
    send_item(stroke_pt(16'd4000, 16'd3000, 16'd0, 32'd9, TOOL_PEN, $urandom, 1'b0));
    send_item(clear_item());
    send_item(stroke_pt(16'd33, 16'd44, 16'd256, 32'd0, TOOL_ERASER, $urandom, 1'b1));
    drain();

    // sample space and record capacity limits
    configure(16'd1, 24'd1);
    send_item(clear_item());
    send_item(stroke_pt(16'd1, 16'd2, 16'd64, 32'd0, TOOL_PEN, $urandom, 1'b0));
    send_item(stroke_pt(16'd3, 16'd4, 16'd64, 32'd1, TOOL_PEN, $urandom, 1'b1));
    send_item(stroke_pt(16'd5, 16'd6, 16'd64, 32'd0, TOOL_PEN, $urandom, 1'b1));
    send_item(stroke_pt(16'd7, 16'd8, 16'd64, 32'd0, TOOL_PEN, $urandom, 1'b1));
    drain();
    configure(16'hFFFF, 24'd5);
    send_item(clear_item());
    send_stroke(3, 1'b1);
    drain();
    // store already holds more than the lowered capacity
    configure(16'hFFFF, 24'd1);
    send_item(stroke_pt(16'd9, 16'd9, 16'd64, 32'd0, TOOL_PEN, $urandom, 1'b1));
    drain();

    rand_base = items_sent;
    for (int ph = 0; ph < 5; ph++) begin
      configure(rc_tab[ph], sc_tab[ph]);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 2) send_item(clear_item());
        else if (r < 7) send_item(noise_item());
        else send_stroke(pick_len(), 1'b0);
      end
      drain();
    end

    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
